[design/hlcfc_pkg.sv]
// package for the header/length/checksum frame checker
// holds header byte constants, frame positions, status codes and field widths
// no dependencies
package hlcfc_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W = 9;
	localparam int STATUS_W = 3;
	localparam int OUT_DATA_W = 32;

	localparam logic [BYTE_W-1:0] HDR0 = 8'h24;
	localparam logic [BYTE_W-1:0] HDR1 = 8'h44;
	localparam logic [BYTE_W-1:0] HDR2 = 8'h54;
	localparam logic [BYTE_W-1:0] HDR3 = 8'h3A;
	localparam logic [POS_W-1:0] FRAME_OVERHEAD = 9'd8;

	localparam logic [POS_W-1:0] POS_HUNT = 9'd0;
	localparam logic [POS_W-1:0] POS_TYPE = 9'd4;
	localparam logic [POS_W-1:0] POS_LEN = 9'd5;

	localparam logic [STATUS_W-1:0] ST_WAITING = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_VALID = 3'd2;
	localparam logic [STATUS_W-1:0] ST_HDR_ERR = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CK_ERR = 3'd4;

	function automatic logic [BYTE_W-1:0] hdr_byte(input logic [1:0] idx);
		logic [BYTE_W-1:0] r;
		case (idx)
			2'd0: r = HDR0;
			2'd1: r = HDR1;
			2'd2: r = HDR2;
			2'd3: r = HDR3;
			default: r = HDR0;
		endcase
		return r;
	endfunction

endpackage

[design/header_length_checksum_frame_checker_unit.sv]
// top level of the header/length/checksum frame checker
// one input register stage and one output register stage, one result per byte
// depends on hlcfc_pkg
//
// Checks received bytes against frames of the form "$DT:", type, length L,
// L payload bytes, an 8-bit wrapping sum of the payload and an end byte that
// is not checked. Every input transfer yields one output transfer carrying a
// status (waiting, incomplete, frame valid, header error, checksum error), the
// type and length of the current frame, and the byte itself when it is payload
// (flagged on tuser). A byte passes from the input register to the output
// register, and a new byte is taken every cycle while the output side keeps
// up; the only loop is the frame position, running sum and held fields,
// updated together as the byte moves into the output register.
module header_length_checksum_frame_checker_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [hlcfc_pkg::BYTE_W-1:0] s_axis_tdata, // [7:0] rx_byte
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [2:0] status, [10:3] frame_type, [18:11] payload_length,
	// [26:19] payload_byte, [31:27] zero
	output logic [hlcfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic m_axis_tuser // [0] payload_strobe
);
	import hlcfc_pkg::*;

	logic s1_valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic out_valid_s2;
	logic [OUT_DATA_W-1:0] out_data_s2;
	logic out_user_s2;

	logic [POS_W-1:0] pos_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] type_q;
	logic [BYTE_W-1:0] len_q;
	logic match_q;

	logic advance;
	logic [POS_W-1:0] ck_pos;
	logic [POS_W-1:0] pos_d;
	logic [BYTE_W-1:0] sum_d;
	logic [BYTE_W-1:0] type_d;
	logic [BYTE_W-1:0] len_d;
	logic match_d;
	logic [STATUS_W-1:0] status_d;
	logic strobe_d;

	assign advance = s1_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !s1_valid_s1 || advance;
	assign ck_pos = {1'b0, len_q} + FRAME_OVERHEAD - 9'd2;

	always_comb begin
		pos_d = pos_q;
		sum_d = sum_q;
		type_d = type_q;
		len_d = len_q;
		match_d = match_q;
		status_d = ST_INCOMPLETE;
		strobe_d = 1'b0;
		if (pos_q == POS_HUNT) begin
			if (byte_s1 == HDR0) begin
				pos_d = 9'd1;
			end else begin
				status_d = ST_WAITING;
			end
		end else if (pos_q < POS_TYPE) begin
			if (byte_s1 == hdr_byte(pos_q[1:0])) begin
				pos_d = pos_q + 9'd1;
			end else begin
				status_d = ST_HDR_ERR;
				pos_d = POS_HUNT;
			end
		end else if (pos_q == POS_TYPE) begin
			type_d = byte_s1;
			pos_d = POS_LEN;
		end else if (pos_q == POS_LEN) begin
			len_d = byte_s1;
			sum_d = '0;
			match_d = 1'b0;
			pos_d = POS_LEN + 9'd1;
		end else if (pos_q < ck_pos) begin
			sum_d = sum_q + byte_s1;
			strobe_d = 1'b1;
			pos_d = pos_q + 9'd1;
		end else if (pos_q == ck_pos) begin
			match_d = (sum_q == byte_s1);
			pos_d = pos_q + 9'd1;
		end else begin
			status_d = match_q ? ST_VALID : ST_CK_ERR;
			pos_d = POS_HUNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_s2 <= 1'b0;
			pos_q <= '0;
			sum_q <= '0;
			type_q <= '0;
			len_q <= '0;
			match_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				s1_valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_s2 <= 1'b1;
				pos_q <= pos_d;
				sum_q <= sum_d;
				type_q <= type_d;
				len_q <= len_d;
				match_q <= match_d;
			end else if (m_axis_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance) begin
			out_data_s2 <= {5'd0, (strobe_d ? byte_s1 : 8'd0), len_d, type_d, status_d};
			out_user_s2 <= strobe_d;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata = out_data_s2;
	assign m_axis_tuser = out_user_s2;

	a_strobe_incomplete: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2:0] == ST_INCOMPLETE)
		else $error("payload transfer without incomplete status");

	a_no_byte_without_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[26:19] == 8'd0)
		else $error("payload byte set without strobe");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= {1'b0, len_q} + FRAME_OVERHEAD - 9'd1)
		else $error("frame position past end byte");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !m_axis_tready |=> $stable(pos_q) && $stable(sum_q))
		else $error("frame state moved while output stalled");

endmodule

[dv/testbench.sv]
// testbench for header_length_checksum_frame_checker_unit
// a directed table, then random frames, header fragments and noise, each
// byte checked against its table entry or a cycle-free frame parser model; depends on hlcfc_pkg
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hlcfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 750;
	localparam int NUM_DIRECTED = 27;
	localparam logic [BYTE_W-1:0] HDR_SEQ [4] = '{HDR0, HDR1, HDR2, HDR3};

	// first member lands in the top bits: {tuser, tdata}
	typedef struct packed {
		logic payload_strobe;
		logic [4:0] pad;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] payload_length;
		logic [BYTE_W-1:0] frame_type;
		logic [STATUS_W-1:0] status;
	} frame_result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx;
		logic typed;
		frame_result_t want;
	} stim_row_t;

	localparam frame_result_t NO_WANT = '0;

	localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{8'hFF, 1'b1, '{1'b0, 5'd0, 8'h00, 8'h00, 8'h00, ST_WAITING}},
		'{8'h24, 1'b1, '{1'b0, 5'd0, 8'h00, 8'h00, 8'h00, ST_INCOMPLETE}},
		'{8'h45, 1'b1, '{1'b0, 5'd0, 8'h00, 8'h00, 8'h00, ST_HDR_ERR}},
		// a repeated dollar sign is an error and is not taken as a new start
		'{8'h24, 1'b0, NO_WANT},
		'{8'h24, 1'b1, '{1'b0, 5'd0, 8'h00, 8'h00, 8'h00, ST_HDR_ERR}},
		'{8'h44, 1'b1, '{1'b0, 5'd0, 8'h00, 8'h00, 8'h00, ST_WAITING}},
		'{8'h24, 1'b0, NO_WANT},
		'{8'h44, 1'b0, NO_WANT},
		'{8'h54, 1'b0, NO_WANT},
		'{8'h3B, 1'b1, '{1'b0, 5'd0, 8'h00, 8'h00, 8'h00, ST_HDR_ERR}},
		// zero length frame
		'{8'h24, 1'b0, NO_WANT},
		'{8'h44, 1'b0, NO_WANT},
		'{8'h54, 1'b0, NO_WANT},
		'{8'h3A, 1'b0, NO_WANT},
		'{8'hFF, 1'b0, NO_WANT},
		'{8'h00, 1'b0, NO_WANT},
		'{8'h00, 1'b0, NO_WANT},
		'{8'hA5, 1'b1, '{1'b0, 5'd0, 8'h00, 8'h00, 8'hFF, ST_VALID}},
		// one payload byte, bad checksum
		'{8'h24, 1'b0, NO_WANT},
		'{8'h44, 1'b0, NO_WANT},
		'{8'h54, 1'b0, NO_WANT},
		'{8'h3A, 1'b0, NO_WANT},
		'{8'h00, 1'b0, NO_WANT},
		'{8'h01, 1'b0, NO_WANT},
		'{8'hFF, 1'b0, NO_WANT},
		'{8'h00, 1'b0, NO_WANT},
		'{8'h5A, 1'b1, '{1'b0, 5'd0, 8'h00, 8'h01, 8'h00, ST_CK_ERR}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [BYTE_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	frame_result_t expected_results [$];
	int unsigned mismatch_count = 0;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;
	logic no_idle = 1'b0;
	logic long_hold_done = 1'b0;

	logic [POS_W-1:0] frame_pos = POS_HUNT;
	logic [BYTE_W-1:0] payload_sum = '0;
	logic [BYTE_W-1:0] held_type = '0;
	logic [BYTE_W-1:0] held_len = '0;
	logic sum_ok = 1'b0;

	header_length_checksum_frame_checker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #4 clk = ~clk;

	task automatic advance_parser(input logic [BYTE_W-1:0] rx, output frame_result_t r);
		logic [POS_W-1:0] ck_at;
		ck_at = {1'b0, held_len} + FRAME_OVERHEAD - 9'd2;
		r = '0;
		r.status = ST_INCOMPLETE;
		if (frame_pos == POS_HUNT) begin
			if (rx == HDR0)
				frame_pos = 9'd1;
			else
				r.status = ST_WAITING;
		end else if (frame_pos < POS_TYPE) begin
			if (rx == HDR_SEQ[frame_pos[1:0]]) begin
				frame_pos = frame_pos + 9'd1;
			end else begin
				r.status = ST_HDR_ERR;
				frame_pos = POS_HUNT;
			end
		end else if (frame_pos == POS_TYPE) begin
			held_type = rx;
			frame_pos = POS_LEN;
		end else if (frame_pos == POS_LEN) begin
			held_len = rx;
			payload_sum = '0;
			sum_ok = 1'b0;
			frame_pos = POS_LEN + 9'd1;
		end else if (frame_pos < ck_at) begin
			payload_sum = payload_sum + rx;
			r.payload_byte = rx;
			r.payload_strobe = 1'b1;
			frame_pos = frame_pos + 9'd1;
		end else if (frame_pos == ck_at) begin
			sum_ok = (payload_sum == rx);
			frame_pos = frame_pos + 9'd1;
		end else begin
			r.status = sum_ok ? ST_VALID : ST_CK_ERR;
			frame_pos = POS_HUNT;
		end
		r.frame_type = held_type;
		r.payload_length = held_len;
	endtask

	// called and returns at a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] rx, input logic typed,
			input frame_result_t typed_want);
		int unsigned gap;
		frame_result_t predicted;
		no_idle = (items_sent >= 150 && items_sent < 260);
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= rx;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		advance_parser(rx, predicted);
		expected_results.push_back(typed ? typed_want : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	initial begin
		int unsigned random_items;
		int unsigned frames;
		int unsigned pick;
		int unsigned len;
		int unsigned k;
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] sum;
		logic drained_once;
		random_items = 0;
		frames = 0;
		drained_once = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		drain_results();

		while (random_items < RANDOM_ITEMS) begin
			if (!drained_once && items_sent >= 600) begin
				drain_results();
				drained_once = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if (frames == 2)
					len = 255;
				else if ($urandom_range(0, 19) == 0)
					len = $urandom_range(13, 60);
				else
					len = $urandom_range(0, 12);
				for (int h = 0; h < 4; h++)
					send_byte(HDR_SEQ[h], 1'b0, NO_WANT);
				send_byte(8'($urandom), 1'b0, NO_WANT);
				send_byte(8'(len), 1'b0, NO_WANT);
				sum = '0;
				for (int i = 0; i < len; i++) begin
					b = 8'($urandom);
					sum = sum + b;
					send_byte(b, 1'b0, NO_WANT);
				end
				if ($urandom_range(0, 4) == 0)
					sum = sum ^ 8'($urandom_range(1, 255));
				send_byte(sum, 1'b0, NO_WANT);
				send_byte(8'($urandom), 1'b0, NO_WANT);
				random_items += len + 8;
				frames++;
			end else if (pick < 90) begin
				// header cut short by a wrong byte
				k = $urandom_range(1, 3);
				for (int h = 0; h < k; h++)
					send_byte(HDR_SEQ[h], 1'b0, NO_WANT);
				b = 8'($urandom);
				if (b == HDR_SEQ[k])
					b[0] = ~b[0];
				send_byte(b, 1'b0, NO_WANT);
				random_items += k + 1;
			end else begin
				k = $urandom_range(1, 4);
				for (int i = 0; i < k; i++)
					send_byte(8'($urandom), 1'b0, NO_WANT);
				random_items += k;
			end
		end

		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		frame_result_t got;
		frame_result_t want;
		int unsigned stall;
		forever begin
			@(negedge clk);
			stall = no_idle ? 0 : $urandom_range(0, 3);
			// long hold so the block backs up and stalls its input
			if (!long_hold_done && items_sent >= 400) begin
				stall = 80;
				long_hold_done = 1'b1;
			end
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			got = {m_axis_tuser, m_axis_tdata};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected transfer, tuser %b tdata %h", $time,
					m_axis_tuser, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					$display("%0t: expected status %0d type %h len %h byte %h strobe %b pad %h",
						$time, want.status, want.frame_type, want.payload_length,
						want.payload_byte, want.payload_strobe, want.pad);
					$display("%0t: actual   status %0d type %h len %h byte %h strobe %b pad %h",
						$time, got.status, got.frame_type, got.payload_length,
						got.payload_byte, got.payload_strobe, got.pad);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
